// ===== src/c8_pkg.sv =====
// shared types, constants and helper functions of the chip8 instruction core
package c8_pkg;

    localparam int unsigned MEM_AW = 12;
    localparam int unsigned PIX_AW = 11;
    localparam int unsigned FONT_BYTES = 80;
    localparam logic [11:0] RESET_START = 12'h200;

    localparam logic [1:0] OP_STEP = 2'd0;
    localparam logic [1:0] OP_MEM_WR = 2'd1;
    localparam logic [1:0] OP_MEM_RD = 2'd2;
    localparam logic [1:0] OP_PIX_RD = 2'd3;

    localparam logic [3:0] FLAG_REG = 4'hF;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [11:0] program_counter;
        logic [15:0] executed_opcode;
        logic        display_changed;
        logic        sound_on;
        logic        waiting_for_key;
    } t_out_item;

    typedef enum logic [4:0] {
        IC_CLS, IC_RET, IC_JP, IC_CALL, IC_SKIP, IC_ALU, IC_ALUF, IC_SETI,
        IC_JPV0, IC_DRW, IC_KEY, IC_SETDT, IC_SETST, IC_ADDI, IC_FONT,
        IC_BCD, IC_STORE, IC_LOAD, IC_BAD
    } t_iclass;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_SWEEP, CMD_MEM_WR, CMD_MEM_RD, CMD_PIX_RD,
        CMD_FETCH_HI, CMD_FETCH_LO, CMD_DECODE, CMD_READ_VY, CMD_OPERANDS,
        CMD_EXEC, CMD_WRES, CMD_CLR, CMD_BCD, CMD_ST_RD, CMD_ST_WR,
        CMD_LD_RD, CMD_LD_WR, CMD_DRW_ROW, CMD_DRW_BITS, CMD_DRW_PIX,
        CMD_DRW_SKIP, CMD_DRW_XOR, CMD_DRW_FLAG, CMD_RETIRE
    } t_cmd;

    typedef enum logic [4:0] {
        ST_SWEEP, ST_IDLE, ST_MWR, ST_MRD, ST_PRD, ST_FETCH_HI, ST_FETCH_LO,
        ST_DECODE, ST_READ_VY, ST_OPERANDS, ST_EXEC, ST_WRES, ST_CLR, ST_BCD,
        ST_ST_RD, ST_ST_WR, ST_LD_RD, ST_LD_WR, ST_DRW_ROW, ST_DRW_BITS,
        ST_DRW_TEST, ST_DRW_XOR, ST_DRW_FLAG, ST_RETIRE
    } t_state;

    typedef struct packed {
        logic accept;
        t_cmd cmd;
    } t_ctl;

    typedef struct packed {
        t_iclass iclass;
        logic    cnt_x;
        logic    cnt_bcd;
        logic    cnt_clr;
        logic    rows_zero;
        logic    row_last;
        logic    col_last;
        logic    bit_set;
        logic    sweep_last;
    } t_status;

    function automatic t_iclass decode_class(input logic [15:0] opc);
        t_iclass c;
        c = IC_BAD;
        unique case (opc[15:12])
            4'h0: begin
                if (opc == 16'h00E0) c = IC_CLS;
                else if (opc == 16'h00EE) c = IC_RET;
            end
            4'h1: c = IC_JP;
            4'h2: c = IC_CALL;
            4'h3, 4'h4: c = IC_SKIP;
            4'h5, 4'h9: begin
                if (opc[3:0] == 4'h0) c = IC_SKIP;
            end
            4'h6, 4'h7, 4'hC: c = IC_ALU;
            4'h8: begin
                unique case (opc[3:0])
                    4'h0, 4'h1, 4'h2, 4'h3: c = IC_ALU;
                    4'h4, 4'h5, 4'h6, 4'h7, 4'hE: c = IC_ALUF;
                    default: c = IC_BAD;
                endcase
            end
            4'hA: c = IC_SETI;
            4'hB: c = IC_JPV0;
            4'hD: c = IC_DRW;
            4'hE: begin
                if (opc[7:0] == 8'h9E || opc[7:0] == 8'hA1) c = IC_SKIP;
            end
            4'hF: begin
                unique case (opc[7:0])
                    8'h07: c = IC_ALU;
                    8'h0A: c = IC_KEY;
                    8'h15: c = IC_SETDT;
                    8'h18: c = IC_SETST;
                    8'h1E: c = IC_ADDI;
                    8'h29: c = IC_FONT;
                    8'h33: c = IC_BCD;
                    8'h55: c = IC_STORE;
                    8'h65: c = IC_LOAD;
                    default: c = IC_BAD;
                endcase
            end
        endcase
        return c;
    endfunction

    // double dabble: hundreds, tens, ones
    function automatic logic [11:0] to_bcd(input logic [7:0] v);
        logic [19:0] s;
        s = {12'd0, v};
        for (int k = 0; k < 8; k++) begin
            if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
            if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
            if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
            s = s << 1;
        end
        return s[19:8];
    endfunction

    function automatic logic [3:0] top_key(input logic [15:0] keys);
        logic [3:0] r;
        r = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (keys[k]) r = 4'(k);
        end
        return r;
    endfunction

endpackage

// ===== src/c8_datapath.sv =====
// chip8 datapath: memories, register file, stack, timers and output register
module c8_datapath #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c8_pkg::t_ctl       i_ctl,
    input  c8_pkg::t_in_item   i_in_item,
    input  logic               i_cfg_we,
    input  logic [11:0]        i_cfg_data,
    output c8_pkg::t_status    o_status,
    output c8_pkg::t_out_item  o_out_item
);

    localparam int unsigned SPW = $clog2(STACK_DEPTH);

    logic [7:0]  r_mem [2**c8_pkg::MEM_AW];
    logic        r_pix [2**c8_pkg::PIX_AW];
    logic [7:0]  r_vreg [16];
    logic [11:0] r_stack [STACK_DEPTH];

    logic [7:0]  r_mem_q;
    logic        r_pix_q;
    logic [7:0]  r_reg_q;
    logic [11:0] r_stk_q;

    c8_pkg::t_in_item  r_item;
    c8_pkg::t_out_item r_out;
    logic [11:0] r_pc, r_i, r_sweep;
    logic [SPW-1:0] r_sp;
    logic [7:0]  r_delay, r_sound;
    logic [7:0]  r_hi, r_vx, r_vy, r_bits;
    logic [15:0] r_opc;
    logic [10:0] r_cnt;
    logic [2:0]  r_col;
    logic        r_hit;

    c8_pkg::t_iclass iclass;
    logic [3:0]  x_idx;
    logic [7:0]  nn;
    logic [11:0] nnn, i_off, pc_next;
    logic [SPW-1:0] sp_inc, sp_dec;
    logic        key_any, skip_ok, flag;
    logic [7:0]  res, rnd_mod;
    logic [8:0]  sum9;
    logic [12:0] isum;
    logic [11:0] bcd;
    logic [4:0]  row5;
    logic [10:0] pix_p;
    logic [7:0]  delay_t, sound_t;

    logic [11:0] mem_a;
    logic [7:0]  mem_wd;
    logic        mem_we, mem_re;
    logic [10:0] pix_a;
    logic        pix_wd, pix_we, pix_re;
    logic [3:0]  reg_a;
    logic [7:0]  reg_wd;
    logic        reg_we, reg_re;

    assign iclass  = c8_pkg::decode_class(r_opc);
    assign x_idx   = r_opc[11:8];
    assign nn      = r_opc[7:0];
    assign nnn     = r_opc[11:0];
    assign i_off   = r_i + {8'd0, r_cnt[3:0]};
    assign key_any = |r_item.key_mask;
    assign sp_inc  = (r_sp == SPW'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec  = (r_sp == '0) ? SPW'(STACK_DEPTH - 1) : r_sp - 1'b1;
    assign rnd_mod = (r_item.random_byte == 8'hFF) ? 8'd0 : r_item.random_byte;
    assign sum9    = {1'b0, r_vx} + {1'b0, r_vy};
    assign isum    = {1'b0, r_i} + {5'd0, r_vx};
    assign bcd     = c8_pkg::to_bcd(r_vx);
    // sprite pixel wraps at the frame size, so only the low row bits count
    assign row5    = 5'(r_vy[4:0] + {1'b0, r_cnt[3:0]});
    assign pix_p   = 11'({3'd0, r_vx} + {8'd0, r_col}) + {row5, 6'd0};

    always_comb begin
        res  = 8'd0;
        flag = 1'b0;
        unique case (r_opc[15:12])
            4'h6: res = nn;
            4'h7: res = r_vx + nn;
            4'hC: res = rnd_mod & nn;
            4'h8: begin
                unique case (r_opc[3:0])
                    4'h0: res = r_vy;
                    4'h1: res = r_vx | r_vy;
                    4'h2: res = r_vx & r_vy;
                    4'h3: res = r_vx ^ r_vy;
                    4'h4: begin res = sum9[7:0]; flag = sum9[8]; end
                    4'h5: begin res = r_vx - r_vy; flag = (r_vy <= r_vx); end
                    4'h6: begin res = {1'b0, r_vx[7:1]}; flag = r_vx[0]; end
                    4'h7: begin res = r_vy - r_vx; flag = (r_vx <= r_vy); end
                    4'hE: begin res = {r_vx[6:0], 1'b0}; flag = r_vx[7]; end
                    default: res = 8'd0;
                endcase
            end
            4'hF: begin
                if (nn == 8'h07) res = r_delay;
                else if (nn == 8'h0A) res = {4'd0, c8_pkg::top_key(r_item.key_mask)};
                else flag = isum[12];
            end
            default: res = 8'd0;
        endcase
    end

    always_comb begin
        unique case (r_opc[15:12])
            4'h3: skip_ok = (r_vx == nn);
            4'h4: skip_ok = (r_vx != nn);
            4'h5: skip_ok = (r_vx == r_vy);
            4'h9: skip_ok = (r_vx != r_vy);
            4'hE: skip_ok = r_item.key_mask[r_vx[3:0]] ^ (nn == 8'hA1);
            default: skip_ok = 1'b0;
        endcase
    end

    always_comb begin
        unique case (iclass)
            c8_pkg::IC_SKIP: pc_next = skip_ok ? r_pc + 12'd4 : r_pc + 12'd2;
            c8_pkg::IC_JP, c8_pkg::IC_CALL: pc_next = nnn;
            c8_pkg::IC_JPV0: pc_next = nnn + {4'd0, r_vx};
            c8_pkg::IC_RET: pc_next = r_stk_q + 12'd2;
            c8_pkg::IC_KEY: pc_next = key_any ? r_pc + 12'd2 : r_pc;
            c8_pkg::IC_BAD: pc_next = r_pc;
            default: pc_next = r_pc + 12'd2;
        endcase
    end

    // a key wait that finds no key skips the timer tick
    always_comb begin
        delay_t = r_delay;
        sound_t = r_sound;
        if (r_item.operation == c8_pkg::OP_STEP &&
            !(iclass == c8_pkg::IC_KEY && !key_any)) begin
            if (r_delay != 8'd0) delay_t = r_delay - 8'd1;
            if (r_sound != 8'd0) sound_t = r_sound - 8'd1;
        end
    end

    always_comb begin
        mem_a  = i_off;
        mem_wd = 8'd0;
        mem_we = 1'b0;
        mem_re = 1'b0;
        pix_a  = pix_p;
        pix_wd = 1'b0;
        pix_we = 1'b0;
        pix_re = 1'b0;
        reg_a  = x_idx;
        reg_wd = res;
        reg_we = 1'b0;
        reg_re = 1'b0;
        unique case (i_ctl.cmd)
            c8_pkg::CMD_SWEEP: begin
                mem_a  = r_sweep;
                mem_wd = (r_sweep < 12'(c8_pkg::FONT_BYTES)) ?
                         c8_pkg::FONT_ROM[r_sweep[6:0]] : 8'd0;
                mem_we = 1'b1;
                pix_a  = r_sweep[10:0];
                pix_we = 1'b1;
                reg_a  = r_sweep[3:0];
                reg_wd = 8'd0;
                reg_we = (r_sweep[11:4] == 8'd0);
            end
            c8_pkg::CMD_MEM_WR: begin
                mem_a  = r_item.address;
                mem_wd = r_item.write_data;
                mem_we = 1'b1;
            end
            c8_pkg::CMD_MEM_RD: begin
                mem_a  = r_item.address;
                mem_re = 1'b1;
            end
            c8_pkg::CMD_PIX_RD: begin
                pix_a  = r_item.address[10:0];
                pix_re = 1'b1;
            end
            c8_pkg::CMD_FETCH_HI: begin
                mem_a  = r_pc;
                mem_re = 1'b1;
            end
            c8_pkg::CMD_FETCH_LO: begin
                mem_a  = r_pc + 12'd1;
                mem_re = 1'b1;
            end
            c8_pkg::CMD_DECODE: begin
                // BNNN needs V0 in the vx slot
                reg_a  = (r_hi[7:4] == 4'hB) ? 4'd0 : r_hi[3:0];
                reg_re = 1'b1;
            end
            c8_pkg::CMD_READ_VY: begin
                reg_a  = r_opc[7:4];
                reg_re = 1'b1;
            end
            c8_pkg::CMD_EXEC: begin
                if (iclass == c8_pkg::IC_ALUF || iclass == c8_pkg::IC_ADDI) begin
                    reg_a  = c8_pkg::FLAG_REG;
                    reg_wd = {7'd0, flag};
                    reg_we = 1'b1;
                end else begin
                    reg_we = (iclass == c8_pkg::IC_ALU) ||
                             (iclass == c8_pkg::IC_KEY && key_any);
                end
            end
            c8_pkg::CMD_WRES: reg_we = 1'b1;
            c8_pkg::CMD_CLR: begin
                pix_a  = r_cnt;
                pix_we = 1'b1;
            end
            c8_pkg::CMD_BCD: begin
                unique case (r_cnt[1:0])
                    2'd0: mem_wd = {4'd0, bcd[11:8]};
                    2'd1: mem_wd = {4'd0, bcd[7:4]};
                    default: mem_wd = {4'd0, bcd[3:0]};
                endcase
                mem_we = 1'b1;
            end
            c8_pkg::CMD_ST_RD: begin
                reg_a  = r_cnt[3:0];
                reg_re = 1'b1;
            end
            c8_pkg::CMD_ST_WR: begin
                mem_wd = r_reg_q;
                mem_we = 1'b1;
            end
            c8_pkg::CMD_LD_RD, c8_pkg::CMD_DRW_ROW: mem_re = 1'b1;
            c8_pkg::CMD_LD_WR: begin
                reg_a  = r_cnt[3:0];
                reg_wd = r_mem_q;
                reg_we = 1'b1;
            end
            c8_pkg::CMD_DRW_PIX: pix_re = 1'b1;
            c8_pkg::CMD_DRW_XOR: begin
                pix_wd = ~r_pix_q;
                pix_we = 1'b1;
            end
            c8_pkg::CMD_DRW_FLAG: begin
                reg_a  = c8_pkg::FLAG_REG;
                reg_wd = {7'd0, r_hit};
                reg_we = 1'b1;
            end
            default: mem_re = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_a] <= mem_wd;
        if (mem_re) r_mem_q <= r_mem[mem_a];
    end

    always_ff @(posedge i_clk) begin
        if (pix_we) r_pix[pix_a] <= pix_wd;
        if (pix_re) r_pix_q <= r_pix[pix_a];
    end

    always_ff @(posedge i_clk) begin
        if (reg_we) r_vreg[reg_a] <= reg_wd;
        if (reg_re) r_reg_q <= r_vreg[reg_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == c8_pkg::CMD_SWEEP && r_sweep < 12'(STACK_DEPTH)) begin
            r_stack[r_sweep[SPW-1:0]] <= 12'd0;
        end else if (i_ctl.cmd == c8_pkg::CMD_EXEC && iclass == c8_pkg::IC_CALL) begin
            r_stack[r_sp] <= r_pc;
        end
        if (i_ctl.cmd == c8_pkg::CMD_EXEC && iclass == c8_pkg::IC_RET) begin
            r_stk_q <= r_stack[sp_dec];
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= c8_pkg::RESET_START;
            r_i     <= 12'd0;
            r_sp    <= '0;
            r_delay <= 8'd0;
            r_sound <= 8'd0;
            r_sweep <= 12'd0;
        end else begin
            if (i_ctl.cmd == c8_pkg::CMD_SWEEP) r_sweep <= r_sweep + 12'd1;
            if (i_ctl.cmd == c8_pkg::CMD_EXEC) begin
                unique case (iclass)
                    c8_pkg::IC_SETI:  r_i <= nnn;
                    c8_pkg::IC_FONT:  r_i <= {2'd0, r_vx, 2'd0} + {4'd0, r_vx};
                    c8_pkg::IC_ADDI:  r_i <= isum[11:0];
                    c8_pkg::IC_SETDT: r_delay <= r_vx;
                    c8_pkg::IC_SETST: r_sound <= r_vx;
                    c8_pkg::IC_CALL:  r_sp <= sp_inc;
                    c8_pkg::IC_RET:   r_sp <= sp_dec;
                    default: r_sp <= r_sp;
                endcase
            end
            if (i_ctl.cmd == c8_pkg::CMD_RETIRE) begin
                r_delay <= delay_t;
                r_sound <= sound_t;
                if (r_item.operation == c8_pkg::OP_STEP) begin
                    r_pc <= pc_next;
                    if (iclass == c8_pkg::IC_STORE || iclass == c8_pkg::IC_LOAD) begin
                        r_i <= r_i + {8'd0, x_idx} + 12'd1;
                    end
                end
            end
            if (i_cfg_we) begin
                r_pc <= i_cfg_data;
            end
        end
    end

    // item and scratch registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) r_item <= i_in_item;
        unique case (i_ctl.cmd)
            c8_pkg::CMD_FETCH_LO: r_hi <= r_mem_q;
            c8_pkg::CMD_DECODE:   r_opc <= {r_hi, r_mem_q};
            c8_pkg::CMD_READ_VY:  r_vx <= r_reg_q;
            c8_pkg::CMD_OPERANDS: begin
                r_vy  <= r_reg_q;
                r_cnt <= 11'd0;
                r_col <= 3'd0;
                r_hit <= 1'b0;
            end
            c8_pkg::CMD_CLR, c8_pkg::CMD_BCD, c8_pkg::CMD_ST_WR, c8_pkg::CMD_LD_WR:
                r_cnt <= r_cnt + 11'd1;
            c8_pkg::CMD_DRW_BITS: begin
                r_bits <= r_mem_q;
                r_col  <= 3'd0;
            end
            c8_pkg::CMD_DRW_SKIP, c8_pkg::CMD_DRW_XOR: begin
                if (i_ctl.cmd == c8_pkg::CMD_DRW_XOR) r_hit <= r_hit | r_pix_q;
                r_col <= r_col + 3'd1;
                if (r_col == 3'd7) r_cnt <= r_cnt + 11'd1;
            end
            default: r_col <= r_col;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == c8_pkg::CMD_RETIRE) begin
            unique case (r_item.operation)
                c8_pkg::OP_MEM_RD: r_out.read_data <= r_mem_q;
                c8_pkg::OP_PIX_RD: r_out.read_data <= {7'd0, r_pix_q};
                default: r_out.read_data <= 8'd0;
            endcase
            if (r_item.operation == c8_pkg::OP_STEP) begin
                r_out.program_counter <= pc_next;
                r_out.executed_opcode <= r_opc;
                r_out.display_changed <= (iclass == c8_pkg::IC_CLS) ||
                                         (iclass == c8_pkg::IC_DRW);
                r_out.waiting_for_key <= (iclass == c8_pkg::IC_KEY) && !key_any;
            end else begin
                r_out.program_counter <= r_pc;
                r_out.executed_opcode <= 16'd0;
                r_out.display_changed <= 1'b0;
                r_out.waiting_for_key <= 1'b0;
            end
            r_out.sound_on <= (sound_t != 8'd0);
        end
    end

    assign o_out_item = r_out;

    assign o_status.iclass     = iclass;
    assign o_status.cnt_x      = (r_cnt[3:0] == x_idx);
    assign o_status.cnt_bcd    = (r_cnt[1:0] == 2'd2);
    assign o_status.cnt_clr    = &r_cnt;
    assign o_status.rows_zero  = (r_opc[3:0] == 4'd0);
    assign o_status.row_last   = (r_cnt[3:0] == r_opc[3:0] - 4'd1);
    assign o_status.col_last   = (r_col == 3'd7);
    assign o_status.bit_set    = r_bits[3'd7 - r_col];
    assign o_status.sweep_last = &r_sweep;

endmodule

// ===== src/c8_control.sv =====
// chip8 controller: sequences fetch, execute, loops and result hand-off
module c8_control (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_operation,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  c8_pkg::t_status   i_status,
    output c8_pkg::t_ctl      o_ctl
);

    c8_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == c8_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= c8_pkg::ST_SWEEP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctl.accept = 1'b0;
        o_ctl.cmd    = c8_pkg::CMD_NONE;
        unique case (r_state)
            c8_pkg::ST_SWEEP: begin
                o_ctl.cmd = c8_pkg::CMD_SWEEP;
                if (i_status.sweep_last) n_state = c8_pkg::ST_IDLE;
            end
            c8_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    unique case (i_in_operation)
                        c8_pkg::OP_STEP:   n_state = c8_pkg::ST_FETCH_HI;
                        c8_pkg::OP_MEM_WR: n_state = c8_pkg::ST_MWR;
                        c8_pkg::OP_MEM_RD: n_state = c8_pkg::ST_MRD;
                        default:           n_state = c8_pkg::ST_PRD;
                    endcase
                end
            end
            c8_pkg::ST_MWR: begin
                o_ctl.cmd = c8_pkg::CMD_MEM_WR;
                n_state = c8_pkg::ST_RETIRE;
            end
            c8_pkg::ST_MRD: begin
                o_ctl.cmd = c8_pkg::CMD_MEM_RD;
                n_state = c8_pkg::ST_RETIRE;
            end
            c8_pkg::ST_PRD: begin
                o_ctl.cmd = c8_pkg::CMD_PIX_RD;
                n_state = c8_pkg::ST_RETIRE;
            end
            c8_pkg::ST_FETCH_HI: begin
                o_ctl.cmd = c8_pkg::CMD_FETCH_HI;
                n_state = c8_pkg::ST_FETCH_LO;
            end
            c8_pkg::ST_FETCH_LO: begin
                o_ctl.cmd = c8_pkg::CMD_FETCH_LO;
                n_state = c8_pkg::ST_DECODE;
            end
            c8_pkg::ST_DECODE: begin
                o_ctl.cmd = c8_pkg::CMD_DECODE;
                n_state = c8_pkg::ST_READ_VY;
            end
            c8_pkg::ST_READ_VY: begin
                o_ctl.cmd = c8_pkg::CMD_READ_VY;
                n_state = c8_pkg::ST_OPERANDS;
            end
            c8_pkg::ST_OPERANDS: begin
                o_ctl.cmd = c8_pkg::CMD_OPERANDS;
                unique case (i_status.iclass)
                    c8_pkg::IC_CLS:   n_state = c8_pkg::ST_CLR;
                    c8_pkg::IC_BCD:   n_state = c8_pkg::ST_BCD;
                    c8_pkg::IC_STORE: n_state = c8_pkg::ST_ST_RD;
                    c8_pkg::IC_LOAD:  n_state = c8_pkg::ST_LD_RD;
                    c8_pkg::IC_DRW:   n_state = i_status.rows_zero ?
                                                c8_pkg::ST_DRW_FLAG : c8_pkg::ST_DRW_ROW;
                    default:          n_state = c8_pkg::ST_EXEC;
                endcase
            end
            c8_pkg::ST_EXEC: begin
                o_ctl.cmd = c8_pkg::CMD_EXEC;
                n_state = (i_status.iclass == c8_pkg::IC_ALUF) ?
                          c8_pkg::ST_WRES : c8_pkg::ST_RETIRE;
            end
            c8_pkg::ST_WRES: begin
                // flag first, result second, so VX wins when X is F
                o_ctl.cmd = c8_pkg::CMD_WRES;
                n_state = c8_pkg::ST_RETIRE;
            end
            c8_pkg::ST_CLR: begin
                o_ctl.cmd = c8_pkg::CMD_CLR;
                if (i_status.cnt_clr) n_state = c8_pkg::ST_RETIRE;
            end
            c8_pkg::ST_BCD: begin
                o_ctl.cmd = c8_pkg::CMD_BCD;
                if (i_status.cnt_bcd) n_state = c8_pkg::ST_RETIRE;
            end
            c8_pkg::ST_ST_RD: begin
                o_ctl.cmd = c8_pkg::CMD_ST_RD;
                n_state = c8_pkg::ST_ST_WR;
            end
            c8_pkg::ST_ST_WR: begin
                o_ctl.cmd = c8_pkg::CMD_ST_WR;
                n_state = i_status.cnt_x ? c8_pkg::ST_RETIRE : c8_pkg::ST_ST_RD;
            end
            c8_pkg::ST_LD_RD: begin
                o_ctl.cmd = c8_pkg::CMD_LD_RD;
                n_state = c8_pkg::ST_LD_WR;
            end
            c8_pkg::ST_LD_WR: begin
                o_ctl.cmd = c8_pkg::CMD_LD_WR;
                n_state = i_status.cnt_x ? c8_pkg::ST_RETIRE : c8_pkg::ST_LD_RD;
            end
            c8_pkg::ST_DRW_ROW: begin
                o_ctl.cmd = c8_pkg::CMD_DRW_ROW;
                n_state = c8_pkg::ST_DRW_BITS;
            end
            c8_pkg::ST_DRW_BITS: begin
                o_ctl.cmd = c8_pkg::CMD_DRW_BITS;
                n_state = c8_pkg::ST_DRW_TEST;
            end
            c8_pkg::ST_DRW_TEST: begin
                if (i_status.bit_set) begin
                    o_ctl.cmd = c8_pkg::CMD_DRW_PIX;
                    n_state = c8_pkg::ST_DRW_XOR;
                end else begin
                    o_ctl.cmd = c8_pkg::CMD_DRW_SKIP;
                    priority if (!i_status.col_last) n_state = c8_pkg::ST_DRW_TEST;
                    else if (i_status.row_last)      n_state = c8_pkg::ST_DRW_FLAG;
                    else                             n_state = c8_pkg::ST_DRW_ROW;
                end
            end
            c8_pkg::ST_DRW_XOR: begin
                o_ctl.cmd = c8_pkg::CMD_DRW_XOR;
                priority if (!i_status.col_last) n_state = c8_pkg::ST_DRW_TEST;
                else if (i_status.row_last)      n_state = c8_pkg::ST_DRW_FLAG;
                else                             n_state = c8_pkg::ST_DRW_ROW;
            end
            c8_pkg::ST_DRW_FLAG: begin
                o_ctl.cmd = c8_pkg::CMD_DRW_FLAG;
                n_state = c8_pkg::ST_RETIRE;
            end
            c8_pkg::ST_RETIRE: begin
                if (out_free) begin
                    o_ctl.cmd   = c8_pkg::CMD_RETIRE;
                    n_out_valid = 1'b1;
                    n_state     = c8_pkg::ST_IDLE;
                end
            end
            default: n_state = c8_pkg::ST_IDLE;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state != c8_pkg::ST_IDLE))
        else $error("accepted item did not start work");

    a_result_from_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == c8_pkg::ST_RETIRE))
        else $error("result raised outside retire");

    a_sweep_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c8_pkg::ST_SWEEP && i_status.sweep_last) |=>
        (r_state == c8_pkg::ST_IDLE))
        else $error("clearing pass did not end in idle");

    a_no_retire_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.cmd == c8_pkg::CMD_RETIRE) |-> (!r_out_valid || i_out_ready))
        else $error("retire overwrote a pending result");

endmodule

// ===== src/chip8_instruction_core.sv =====
// CHIP-8 core top level: the controller and the datapath joined by command and status.
// After reset the core runs a clearing pass (font load, memory, frame, registers and
// stack) before it takes its first item; configuration writes are taken at any time.
// Memory writes and reads and pixel reads go from their access state to retire, where
// the result waits until the output is free. A step does two fetch reads and two
// register reads over single-port memories, then executes and retires; ALU ops that
// set VF add a result write, BCD writes three digits, block store and load read then
// write each of X+1 registers, display clear writes one pixel a cycle, and DXYN walks
// the 8*N sprite columns, reading then writing each set pixel over the single pixel port.
module chip8_instruction_core #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  c8_pkg::t_in_item   i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output c8_pkg::t_out_item  o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [11:0]        i_cfg_data
);

    c8_pkg::t_ctl    ctl;
    c8_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    c8_control u_control (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_operation (i_in_item.operation),
        .o_in_ready     (o_in_ready),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .i_status       (status),
        .o_ctl          (ctl)
    );

    c8_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule
